// ===== sv/pmld_pkg.sv =====
// Shared types and constants for the pairwise mean loss per draw unit.
package pmld_pkg;

  localparam int MAX_DRAWS_DEF     = 64;
  localparam int MAX_RESPONSES_DEF = 64;

  localparam logic [1:0] MODE_QUAD  = 2'd0;
  localparam logic [1:0] MODE_ABS   = 2'd1;
  localparam logic [1:0] MODE_PASS  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_DRAWS = 2'd1;
  localparam logic [1:0] REG_RESPS = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [47:0] LOSS_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] response_value;
    logic [47:0]        fallback_loss;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  draw_index;
    logic [47:0] mean_loss;
    logic        last_result;
  } out_item_t;

  // one complete set handed from loader to compute engine
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] draws;
    logic [6:0] resps;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DIV,
    ST_FB,
    ST_EMIT
  } back_state_t;

endpackage

// ===== sv/pmld_front.sv =====
// Loader: tracks row/column position, writes the stores, queues completed sets.
module pmld_front #(
  parameter int MAX_DRAWS     = pmld_pkg::MAX_DRAWS_DEF,
  parameter int MAX_RESPONSES = pmld_pkg::MAX_RESPONSES_DEF,
  parameter int DAW = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1,
  parameter int CAW = (MAX_RESPONSES > 1) ? $clog2(MAX_RESPONSES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  pmld_pkg::in_item_t   in_item,
  input  logic [1:0]           mode,
  input  logic [6:0]           draws,
  input  logic [6:0]           resps,
  input  logic                 restart,
  input  logic                 job_pop,
  output logic                 mem_we,
  output logic [DAW+CAW-1:0]   mem_waddr,
  output logic [31:0]          mem_wdata,
  output logic                 fb_we,
  output logic [DAW-1:0]       fb_waddr,
  output logic [47:0]          fb_wdata,
  output logic                 job_valid,
  output pmld_pkg::job_t       job
);
  import pmld_pkg::*;

  logic [DAW-1:0] row_r, row_nxt;
  logic [CAW-1:0] col_r, col_nxt;
  logic           col_last, row_last, push;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign col_last = (9'(col_r) + 9'd1) == {2'b00, resps};
  assign row_last = (8'(row_r) + 8'd1) == {1'b0, draws};
  assign push     = accept && col_last && row_last;

  // store writes
  assign mem_we    = accept;
  assign mem_waddr = {row_r, col_r};
  assign mem_wdata = in_item.response_value;
  assign fb_we     = accept && (col_r == '0);
  assign fb_waddr  = row_r;
  assign fb_wdata  = in_item.fallback_loss;

  // position advance
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // two-entry set queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (job_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, job_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{mode: mode, draws: draws, resps: resps};
    end
  end

  assign job_valid = cnt_r != 2'd0;
  assign job       = q_r[rp_r];

endmodule

// ===== sv/pmld_back.sv =====
// Compute engine: pairwise difference pipeline, bit-serial divide, result emit.
module pmld_back #(
  parameter int MAX_DRAWS     = pmld_pkg::MAX_DRAWS_DEF,
  parameter int MAX_RESPONSES = pmld_pkg::MAX_RESPONSES_DEF,
  parameter int DAW = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1,
  parameter int CAW = (MAX_RESPONSES > 1) ? $clog2(MAX_RESPONSES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mem_we,
  input  logic [DAW+CAW-1:0]   mem_waddr,
  input  logic [31:0]          mem_wdata,
  input  logic                 fb_we,
  input  logic [DAW-1:0]       fb_waddr,
  input  logic [47:0]          fb_wdata,
  input  logic                 job_valid,
  input  pmld_pkg::job_t       job,
  output logic                 job_pop,
  output logic                 busy,
  output logic                 out_valid,
  output pmld_pkg::out_item_t  out_item
);
  import pmld_pkg::*;

  localparam int MAW   = DAW + CAW;
  localparam int DEPTH = 1 << MAW;
  localparam int ACCW  = 65 + DAW + CAW;
  localparam int BCW   = $clog2(ACCW);

  back_state_t state_r, state_nxt;

  logic [31:0] mem    [DEPTH];
  logic [47:0] fb_mem [1 << DAW];

  job_t           job_r;
  logic [DAW-1:0] i_r, m_r;
  logic [CAW-1:0] c_r;
  logic           v1_r, v2_r, v3_r;
  logic [31:0]    rda_r, rdb_r;
  logic [32:0]    mag_r;
  logic [64:0]    term_r;
  logic [ACCW-1:0] acc_r;
  logic [6:0]     rem_r;
  logic [BCW-1:0] bit_r;
  logic [47:0]    fb_r;

  logic issue, fb_rd;
  logic c_last, m_last, i_last, quad, pass, pipe_empty, bit_done;
  logic signed [32:0] diff;
  logic [65:0]    sq;
  logic [7:0]     trial;
  logic           q_bit;
  logic [47:0]    loss;

  assign quad       = job_r.mode == MODE_QUAD;
  assign pass       = (job_r.mode != MODE_QUAD) && (job_r.mode != MODE_ABS);
  assign c_last     = (9'(c_r) + 9'd1) == {2'b00, job_r.resps};
  assign m_last     = (8'(m_r) + 8'd1) == {1'b0, job_r.draws};
  assign i_last     = (8'(i_r) + 8'd1) == {1'b0, job_r.draws};
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign bit_done   = bit_r == BCW'(ACCW - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) state_nxt = ((job.mode != MODE_QUAD) && (job.mode != MODE_ABS))
                                   ? ST_FB : ST_RUN;
      end
      ST_RUN:   if (c_last && m_last) state_nxt = ST_FLUSH;
      ST_FLUSH: if (pipe_empty) state_nxt = ST_DIV;
      ST_DIV:   if (bit_done) state_nxt = ST_EMIT;
      ST_FB:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (i_last) state_nxt = ST_IDLE;
        else state_nxt = pass ? ST_FB : ST_RUN;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    job_pop   = (state_r == ST_IDLE) && job_valid;
    issue     = state_r == ST_RUN;
    fb_rd     = state_r == ST_FB;
    out_valid = state_r == ST_EMIT;
    busy      = state_r != ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
    end
  end

  // stores: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rda_r <= mem[{i_r, c_r}];
    rdb_r <= mem[{m_r, c_r}];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    if (fb_rd) fb_r <= fb_mem[i_r];
  end

  // difference, magnitude, square
  assign diff = $signed({rda_r[31], rda_r}) - $signed({rdb_r[31], rdb_r});
  assign sq   = mag_r * mag_r;

  always_ff @(posedge clk) begin
    mag_r  <= diff[32] ? 33'(-diff) : 33'(diff);
    term_r <= quad ? sq[64:0] : {32'd0, mag_r};
  end

  // restoring divide step by the draw count
  assign trial = {rem_r, acc_r[ACCW-1]};
  assign q_bit = trial >= {1'b0, job_r.draws};

  // counters, accumulator and divider
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        job_r <= job;
        i_r   <= '0;
        m_r   <= '0;
        c_r   <= '0;
        acc_r <= '0;
      end
      ST_RUN: begin
        if (v3_r) acc_r <= acc_r + ACCW'(term_r);
        if (c_last) begin
          c_r <= '0;
          m_r <= m_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
        rem_r <= '0;
        bit_r <= '0;
      end
      ST_FLUSH: begin
        if (v3_r) acc_r <= acc_r + ACCW'(term_r);
      end
      ST_DIV: begin
        rem_r <= q_bit ? 7'(trial - {1'b0, job_r.draws}) : trial[6:0];
        acc_r <= {acc_r[ACCW-2:0], q_bit};
        bit_r <= bit_r + 1'b1;
      end
      ST_FB: begin
      end
      ST_EMIT: begin
        i_r   <= i_r + 1'b1;
        m_r   <= '0;
        c_r   <= '0;
        acc_r <= '0;
      end
      default: begin
      end
    endcase
  end

  // scale and saturate the quotient, or pass the fallback loss through
  always_comb begin
    if (pass) loss = fb_r;
    else if (quad) loss = (|acc_r[ACCW-1:64]) ? LOSS_MAX : acc_r[63:16];
    else loss = (|acc_r[ACCW-1:48]) ? LOSS_MAX : acc_r[47:0];
  end

  assign out_item = '{draw_index: 6'(i_r), mean_loss: loss, last_result: i_last};

endmodule

// ===== sv/pairwise_mean_loss_per_draw_unit.sv =====
// Loading: one item per cycle while busy is low; busy is high from set completion to last result.
// Compute modes: after the set start, each draw issues every pair with the draws and responses,
// flushes the pipeline, divides by the draw count in the bit-serial divider and emits its result,
// using the single difference unit. Pass-through mode: per draw, the fallback loss is read, then emitted.
// Results are one-cycle strobes; the receiver cannot stall. Sync active-low reset clears
// registers to mode 0, 64 draws, 64 responses and load position 0; stores stay unwritten.
module pairwise_mean_loss_per_draw_unit #(
  parameter int MAX_DRAWS     = pmld_pkg::MAX_DRAWS_DEF,
  parameter int MAX_RESPONSES = pmld_pkg::MAX_RESPONSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pmld_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output pmld_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import pmld_pkg::*;

  localparam int DAW = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1;
  localparam int CAW = (MAX_RESPONSES > 1) ? $clog2(MAX_RESPONSES) : 1;

  logic [1:0] mode_r;
  logic [6:0] draws_r, resps_r;
  logic [6:0] draws_eff, resps_eff;
  logic       cfg_wr, restart, accept;

  logic               mem_we, fb_we, job_valid, job_pop, back_busy;
  logic [DAW+CAW-1:0] mem_waddr;
  logic [31:0]        mem_wdata;
  logic [DAW-1:0]     fb_waddr;
  logic [47:0]        fb_wdata;
  job_t               job;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && ((paddr[3:2] == REG_DRAWS) || (paddr[3:2] == REG_RESPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_QUAD;
      draws_r <= 7'd64;
      resps_r <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE:  mode_r  <= pwdata[1:0];
        REG_DRAWS: draws_r <= pwdata[6:0];
        REG_RESPS: resps_r <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = {30'd0, mode_r};
      REG_DRAWS: prdata = {25'd0, draws_r};
      REG_RESPS: prdata = {25'd0, resps_r};
      default:   prdata = 32'd0;
    endcase
  end

  // clamp sizes into the supported range
  always_comb begin
    if (draws_r == 7'd0) draws_eff = 7'd1;
    else if (int'(draws_r) > MAX_DRAWS) draws_eff = 7'(MAX_DRAWS);
    else draws_eff = draws_r;
    if (resps_r == 7'd0) resps_eff = 7'd1;
    else if (int'(resps_r) > MAX_RESPONSES) resps_eff = 7'(MAX_RESPONSES);
    else resps_eff = resps_r;
  end

  assign busy   = job_valid || back_busy;
  assign accept = start && !busy;

  pmld_front #(
    .MAX_DRAWS(MAX_DRAWS), .MAX_RESPONSES(MAX_RESPONSES), .DAW(DAW), .CAW(CAW)
  ) u_front (
    .clk, .rst_n, .accept, .in_item,
    .mode(mode_r), .draws(draws_eff), .resps(resps_eff), .restart, .job_pop,
    .mem_we, .mem_waddr, .mem_wdata, .fb_we, .fb_waddr, .fb_wdata,
    .job_valid, .job
  );

  pmld_back #(
    .MAX_DRAWS(MAX_DRAWS), .MAX_RESPONSES(MAX_RESPONSES), .DAW(DAW), .CAW(CAW)
  ) u_back (
    .clk, .rst_n, .mem_we, .mem_waddr, .mem_wdata, .fb_we, .fb_waddr, .fb_wdata,
    .job_valid, .job, .job_pop, .busy(back_busy), .out_valid, .out_item
  );

  // results only come out while the engine holds a set
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> back_busy) else $error("result outside a set");

  // no load is taken while the engine works
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> !mem_we) else $error("store written during compute");

  // the final result of a set ends the engine's run
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |=> !back_busy || job_pop)
    else $error("engine still running after last result");

  // a set pops from the queue only into an idle engine
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid && !$past(out_valid && !out_item.last_result))
    else $error("queue popped mid-set");

endmodule
